/* rtl/core/psba_pkg.sv */
`default_nettype none
package psba_pkg;

   // Fixed geometry and field widths
   localparam int NUM_BIN_SLOTS         = 4096;
   localparam int BIN_W                 = 12;
   localparam int NUM_CHAN              = 6;
   localparam int NUM_AXES              = 3;
   localparam int DATA_W                = 32;
   localparam int EXT_W                 = 31;
   localparam int MODE_W                = 6;
   localparam int CNT_W                 = 32;
   localparam int ACC_W                 = 64;
   localparam int TERM_W                = 49;
   localparam int FRAC_W                = 16;
   localparam int DEFAULT_BINS_PER_AXIS = 16;

   // Mode bit positions (bits 0..2 project x, y, z)
   localparam int MODE_VEL    = 3;
   localparam int MODE_STRESS = 4;
   localparam int MODE_AVG    = 5;

   localparam logic [EXT_W-1:0]  EXTENT_RESET = 31'd65536;
   localparam logic [MODE_W-1:0] MODE_RESET   = 6'd56;

   // Velocity components that form each channel's product
   localparam logic [1:0] CHAN_A [NUM_CHAN] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] CHAN_B [NUM_CHAN] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

   localparam int CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_EXTENT_X = 3'd3,
      CSR_EXTENT_Y = 3'd4,
      CSR_EXTENT_Z = 3'd5,
      CSR_MODE     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
      logic signed [DATA_W-1:0] stress_xx;
      logic signed [DATA_W-1:0] stress_xy;
      logic signed [DATA_W-1:0] stress_xz;
      logic signed [DATA_W-1:0] stress_yy;
      logic signed [DATA_W-1:0] stress_yz;
      logic signed [DATA_W-1:0] stress_zz;
   } req_type;

   typedef struct packed {
      logic                    in_grid;
      logic [BIN_W-1:0]        bin_index;
      logic [CNT_W-1:0]        bin_count;
      logic signed [ACC_W-1:0] chan_xx;
      logic signed [ACC_W-1:0] chan_xy;
      logic signed [ACC_W-1:0] chan_xz;
      logic signed [ACC_W-1:0] chan_yy;
      logic signed [ACC_W-1:0] chan_yz;
      logic signed [ACC_W-1:0] chan_zz;
   } rsp_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][DATA_W-1:0] origin;
      logic [NUM_AXES-1:0][EXT_W-1:0]  extent;
      logic [MODE_W-1:0]               mode;
   } cfg_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic                              in_grid;
      logic [BIN_W-1:0]                  bin;
      logic [NUM_CHAN-1:0][TERM_W-1:0]   term;
   } mid_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage
`default_nettype wire

/* rtl/core/psba_ram.sv */
`default_nettype none
module psba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/psba_fifo.sv */
`default_nettype none
module psba_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output      logic         full,
   input  wire logic [W-1:0] wdata,
   input  wire logic         pop,
   output      logic         empty,
   output      logic [W-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store a transfer
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

endmodule
`default_nettype wire

/* rtl/core/psba_div.sv */
`default_nettype none
module psba_div #(
   parameter int DVD_W = 64,
   parameter int DVS_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output      logic             done,
   output      logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  work_ff, work_in;
   logic [DVS_W:0]    rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic              fits;

   // One quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff[DVS_W-1:0], work_ff[DVD_W-1]};
      fits    = (trial >= {1'b0, divisor});
      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         step_in = STEP_W'(DVD_W);
      end else if (step_ff != '0) begin
         rem_in  = fits ? (trial - {1'b0, divisor}) : trial;
         work_in = {work_ff[DVD_W-2:0], fits};
         step_in = step_ff - 1'b1;
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule
`default_nettype wire

/* rtl/core/psba_front.sv */
`default_nettype none
module psba_front #(
   parameter int BINS_PER_AXIS = psba_pkg::DEFAULT_BINS_PER_AXIS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire psba_pkg::cfg_type         cfg,
   input  wire psba_pkg::back_status_type back_status,
   input  wire logic                      req_push,
   output      logic                      req_full,
   input  wire psba_pkg::req_type         req_data,
   output      logic                      mid_push,
   input  wire logic                      mid_full,
   output      psba_pkg::mid_type         mid_data
);

   localparam int NB_W  = $clog2(BINS_PER_AXIS + 1);
   localparam int ROW_W = 2 * NB_W;
   localparam int SUM_W = 3 * NB_W + psba_pkg::BIN_W;
   localparam int NA    = psba_pkg::NUM_AXES;
   localparam int NC    = psba_pkg::NUM_CHAN;
   localparam int DW    = psba_pkg::DATA_W;
   localparam int TW    = psba_pkg::TERM_W;
   localparam int AW    = psba_pkg::ACC_W;

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_AXIS = 6'b000010,
      F_ROW  = 6'b000100,
      F_BIN  = 6'b001000,
      F_TERM = 6'b010000,
      F_PUSH = 6'b100000
   } fstate_type;

   fstate_type                  state_ff, state_in;
   psba_pkg::req_type           item_ff, item_in;
   logic [NA-1:0]               ok_ff, ok_in;
   logic [NB_W-1:0]             idx_ff [NA];
   logic [NB_W-1:0]             idx_in [NA];
   logic [NB_W-1:0]             nb_ff [NA];
   logic [NB_W-1:0]             nb_in [NA];
   logic [ROW_W-1:0]            row_ff, row_in;
   logic                        valid_ff, valid_in;
   logic [psba_pkg::BIN_W-1:0]  bin_ff, bin_in;
   logic [2:0]                  ch_ff, ch_in;
   logic signed [AW-1:0]        prod_ff, prod_in;
   logic [TW-1:0]               term_ff [NC];
   logic [TW-1:0]               term_in [NC];

   logic [DW-1:0]               pos_a [NA];
   logic [DW-1:0]               vel_a [NA];
   logic [DW-1:0]               str_a [NC];
   logic [DW:0]                 diff [NA];
   logic [DW:0]                 mag [NA];
   logic [14:0]                 ext_int [NA];
   logic [16:0]                 quot [NA];
   logic [NB_W-1:0]             nb_free [NA];
   logic [SUM_W-1:0]            bin_sum;
   logic [2:0]                  ch_sel;
   logic signed [DW-1:0]        va, vb;
   logic signed [AW-1:0]        vel_sh;
   logic [TW-1:0]               vel_term, str_term;

   assign req_full = (state_ff != F_IDLE) || back_status.clearing;
   assign mid_push = (state_ff == F_PUSH);

   always_comb begin
      mid_data.in_grid = valid_ff;
      mid_data.bin     = bin_ff;
      for (int j = 0; j < NC; j++) begin
         mid_data.term[j] = term_ff[j];
      end
   end

   // Unpack the held record
   always_comb begin
      pos_a[0] = item_ff.pos_x;
      pos_a[1] = item_ff.pos_y;
      pos_a[2] = item_ff.pos_z;
      vel_a[0] = item_ff.vel_x;
      vel_a[1] = item_ff.vel_y;
      vel_a[2] = item_ff.vel_z;
      str_a[0] = item_ff.stress_xx;
      str_a[1] = item_ff.stress_xy;
      str_a[2] = item_ff.stress_xz;
      str_a[3] = item_ff.stress_yy;
      str_a[4] = item_ff.stress_yz;
      str_a[5] = item_ff.stress_zz;
   end

   // Classify each axis: offset, range check, bin number
   always_comb begin
      for (int c = 0; c < NA; c++) begin
         diff[c]    = {pos_a[c][DW-1], pos_a[c]} - {cfg.origin[c][DW-1], cfg.origin[c]};
         mag[c]     = diff[c][DW] ? (~diff[c] + 1'b1) : diff[c];
         ext_int[c] = cfg.extent[c][psba_pkg::EXT_W-1:psba_pkg::FRAC_W];
         quot[c]    = diff[c][DW:psba_pkg::FRAC_W];
         nb_free[c] = (32'(ext_int[c]) > 32'(BINS_PER_AXIS)) ?
                      NB_W'(BINS_PER_AXIS) : NB_W'(ext_int[c]);
         idx_in[c]  = idx_ff[c];
         nb_in[c]   = nb_ff[c];
         ok_in[c]   = ok_ff[c];
         if (state_ff == F_AXIS) begin
            if (cfg.mode[c]) begin
               // one bin spanning the extent on each side of the origin
               ok_in[c]  = (mag[c] < {2'b00, cfg.extent[c]});
               idx_in[c] = '0;
               nb_in[c]  = NB_W'(1);
            end else if (diff[c][DW]) begin
               // just below the origin truncates into bin 0, if the axis has one
               ok_in[c]  = (mag[c][DW:psba_pkg::FRAC_W] == '0) && (nb_free[c] != '0);
               idx_in[c] = '0;
               nb_in[c]  = nb_free[c];
            end else begin
               ok_in[c]  = (32'(quot[c]) < 32'(nb_free[c]));
               idx_in[c] = quot[c][NB_W-1:0];
               nb_in[c]  = nb_free[c];
            end
         end
      end
   end

   // Velocity product and channel terms
   always_comb begin
      ch_sel   = (ch_ff < 3'(NC)) ? ch_ff : 3'd0;
      va       = vel_a[psba_pkg::CHAN_A[ch_sel]];
      vb       = vel_a[psba_pkg::CHAN_B[ch_sel]];
      prod_in  = va * vb;
      vel_sh   = prod_ff >>> psba_pkg::FRAC_W;
      vel_term = cfg.mode[psba_pkg::MODE_VEL] ? vel_sh[TW-1:0] : '0;
      str_term = '0;
      for (int j = 0; j < NC; j++) begin
         term_in[j] = term_ff[j];
         if ((ch_ff - 3'd1) == 3'(j)) begin
            str_term = cfg.mode[psba_pkg::MODE_STRESS] ?
                       {{(TW - DW){str_a[j][DW-1]}}, str_a[j]} : '0;
         end
      end
      for (int j = 0; j < NC; j++) begin
         if ((state_ff == F_TERM) && (ch_ff != '0) && ((ch_ff - 3'd1) == 3'(j))) begin
            term_in[j] = str_term + vel_term;
         end
      end
   end

   assign bin_sum = SUM_W'(idx_ff[0]) + SUM_W'(nb_ff[0]) * SUM_W'(row_ff);

   // Sequence one record
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      row_in   = row_ff;
      valid_in = valid_ff;
      bin_in   = bin_ff;
      ch_in    = ch_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_push && !req_full) begin
               item_in  = req_data;
               state_in = F_AXIS;
            end
         end
         F_AXIS: begin
            state_in = F_ROW;
         end
         F_ROW: begin
            row_in   = ROW_W'(idx_ff[1]) + ROW_W'(nb_ff[1]) * ROW_W'(idx_ff[2]);
            state_in = F_BIN;
         end
         F_BIN: begin
            valid_in = (&ok_ff) && (bin_sum < SUM_W'(psba_pkg::NUM_BIN_SLOTS));
            bin_in   = bin_sum[psba_pkg::BIN_W-1:0];
            ch_in    = '0;
            state_in = valid_in ? F_TERM : F_PUSH;
         end
         F_TERM: begin
            ch_in = ch_ff + 3'd1;
            if (ch_ff == 3'(NC)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!mid_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff  <= item_in;
      ok_ff    <= ok_in;
      row_ff   <= row_in;
      valid_ff <= valid_in;
      bin_ff   <= bin_in;
      ch_ff    <= ch_in;
      prod_ff  <= prod_in;
      for (int c = 0; c < NA; c++) begin
         idx_ff[c] <= idx_in[c];
         nb_ff[c]  <= nb_in[c];
      end
      for (int j = 0; j < NC; j++) begin
         term_ff[j] <= term_in[j];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/psba_back.sv */
`default_nettype none
module psba_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      avg_en,
   input  wire logic                      mid_empty,
   output      logic                      mid_pop,
   input  wire psba_pkg::mid_type         mid_data,
   output      logic                      out_push,
   input  wire logic                      out_full,
   output      psba_pkg::rsp_type         out_data,
   output      psba_pkg::back_status_type status
);

   localparam int NC    = psba_pkg::NUM_CHAN;
   localparam int AW    = psba_pkg::ACC_W;
   localparam int TW    = psba_pkg::TERM_W;
   localparam int CW    = psba_pkg::CNT_W;
   localparam int BW    = psba_pkg::BIN_W;
   localparam int WIDE  = AW + 1;

   typedef enum logic [6:0] {
      B_CLEAR  = 7'b0000001,
      B_IDLE   = 7'b0000010,
      B_READ   = 7'b0000100,
      B_UPDATE = 7'b0001000,
      B_DSTART = 7'b0010000,
      B_DWAIT  = 7'b0100000,
      B_PUSH   = 7'b1000000
   } bstate_type;

   bstate_type        state_ff, state_in;
   logic [BW-1:0]     clr_ff, clr_in;
   psba_pkg::mid_type job_ff, job_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     sum_ff [NC];
   logic [AW-1:0]     sum_in [NC];
   logic [2:0]        ch_ff, ch_in;

   logic              wr_en;
   logic [BW-1:0]     wr_addr;
   logic [CW-1:0]     cnt_rd, cnt_new, cnt_wr;
   logic [AW-1:0]     sum_rd [NC];
   logic [AW-1:0]     sum_new [NC];
   logic [AW-1:0]     sum_wr [NC];
   logic [WIDE-1:0]   wide [NC];
   logic [AW-1:0]     cur_sum;
   logic [AW-1:0]     div_mag;
   logic              div_start, div_done;
   logic [AW-1:0]     div_q;

   // Count and sum stores, one row per bin
   assign wr_en   = (state_ff == B_CLEAR) || (state_ff == B_UPDATE);
   assign wr_addr = (state_ff == B_CLEAR) ? clr_ff : job_ff.bin;
   assign cnt_wr  = (state_ff == B_CLEAR) ? '0 : cnt_new;

   psba_ram #(.WIDTH(CW), .DEPTH(psba_pkg::NUM_BIN_SLOTS)) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cnt_wr),
      .rd_addr (job_ff.bin),
      .rd_data (cnt_rd)
   );

   for (genvar j = 0; j < NC; j++) begin : g_sum
      assign sum_wr[j] = (state_ff == B_CLEAR) ? '0 : sum_new[j];
      psba_ram #(.WIDTH(AW), .DEPTH(psba_pkg::NUM_BIN_SLOTS)) u_sum_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (sum_wr[j]),
         .rd_addr (job_ff.bin),
         .rd_data (sum_rd[j])
      );
   end

   // Saturating count and sums
   always_comb begin
      cnt_new = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
      for (int j = 0; j < NC; j++) begin
         wide[j] = {sum_rd[j][AW-1], sum_rd[j]} +
                   {{(WIDE - TW){job_ff.term[j][TW-1]}}, job_ff.term[j]};
         if (wide[j][WIDE-1] != wide[j][AW-1]) begin
            sum_new[j] = wide[j][WIDE-1] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
         end else begin
            sum_new[j] = wide[j][AW-1:0];
         end
      end
   end

   // Divide one channel at a time by the count
   assign cur_sum   = sum_ff[ch_ff];
   assign div_mag   = cur_sum[AW-1] ? (~cur_sum + 1'b1) : cur_sum;
   assign div_start = (state_ff == B_DSTART);

   psba_div #(.DVD_W(AW), .DVS_W(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign mid_pop         = (state_ff == B_IDLE) && !mid_empty;
   assign out_push        = (state_ff == B_PUSH);
   assign status.clearing = (state_ff == B_CLEAR);

   always_comb begin
      out_data.in_grid   = job_ff.in_grid;
      out_data.bin_index = job_ff.in_grid ? job_ff.bin : '0;
      out_data.bin_count = count_ff;
      out_data.chan_xx   = sum_ff[0];
      out_data.chan_xy   = sum_ff[1];
      out_data.chan_xz   = sum_ff[2];
      out_data.chan_yy   = sum_ff[3];
      out_data.chan_yz   = sum_ff[4];
      out_data.chan_zz   = sum_ff[5];
   end

   // Clear, read, update, optionally average, deliver
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      job_in   = job_ff;
      count_in = count_ff;
      ch_in    = ch_ff;
      for (int j = 0; j < NC; j++) begin
         sum_in[j] = sum_ff[j];
      end
      unique case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!mid_empty) begin
               job_in = mid_data;
               if (mid_data.in_grid) begin
                  state_in = B_READ;
               end else begin
                  count_in = '0;
                  for (int j = 0; j < NC; j++) begin
                     sum_in[j] = '0;
                  end
                  state_in = B_PUSH;
               end
            end
         end
         B_READ: begin
            state_in = B_UPDATE;
         end
         B_UPDATE: begin
            count_in = cnt_new;
            for (int j = 0; j < NC; j++) begin
               sum_in[j] = sum_new[j];
            end
            ch_in    = '0;
            state_in = avg_en ? B_DSTART : B_PUSH;
         end
         B_DSTART: begin
            state_in = B_DWAIT;
         end
         B_DWAIT: begin
            if (div_done) begin
               for (int j = 0; j < NC; j++) begin
                  if (ch_ff == 3'(j)) begin
                     sum_in[j] = sum_ff[j][AW-1] ? (~div_q + 1'b1) : div_q;
                  end
               end
               ch_in    = ch_ff + 3'd1;
               state_in = (ch_ff == 3'(NC - 1)) ? B_PUSH : B_DSTART;
            end
         end
         B_PUSH: begin
            if (!out_full) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      job_ff   <= job_in;
      count_ff <= count_in;
      ch_ff    <= ch_in;
      for (int j = 0; j < NC; j++) begin
         sum_ff[j] <= sum_in[j];
      end
   end

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == B_DWAIT))
      else $error("divider finished outside its wait state");

   a_update_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_UPDATE) |-> job_ff.in_grid)
      else $error("off-grid item reached the stores");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.in_grid) |-> (out_data.bin_count != '0))
      else $error("accumulated result with zero count");

endmodule
`default_nettype wire

/* rtl/core/particle_stress_bin_accumulator.sv */
// Particle stress bin accumulator. Each pushed record is placed in a spatial bin and,
// when in the grid, adds its stress and/or velocity product terms to that bin's six
// saturating 64-bit sums and its count; one result per record is popped from the rsp_
// queue. After reset a clearing pass writes all 4096 bins, during which req_full stays
// high (configuration writes are still taken). The front takes one record at a time
// through the accept step, three classify steps, seven steps of its one shared velocity
// multiplier and the hand-off, which waits while the queue is full (an off-grid record
// skips the multiplier steps). The back reads, updates and writes the bin of each
// in-grid record; with averaging on it then makes six passes of one bit-serial divider.
// Front and back are split by a two-entry queue.
`default_nettype none
module particle_stress_bin_accumulator #(
   parameter int BINS_PER_AXIS = psba_pkg::DEFAULT_BINS_PER_AXIS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output      logic                                req_full,
   input  wire psba_pkg::req_type                   req_data,
   output      logic                                rsp_empty,
   input  wire logic                                rsp_pop,
   output      psba_pkg::rsp_type                   rsp_data,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [psba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [psba_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int MID_W = $bits(psba_pkg::mid_type);
   localparam int RSP_W = $bits(psba_pkg::rsp_type);

   psba_pkg::cfg_type         cfg_ff, cfg_in;
   psba_pkg::back_status_type back_status;
   logic                      mid_push, mid_full, mid_pop, mid_empty;
   logic [MID_W-1:0]          mid_wdata, mid_rdata;
   psba_pkg::mid_type         mid_front, mid_back;
   logic                      out_push, out_full;
   psba_pkg::rsp_type         out_data;
   logic [RSP_W-1:0]          out_wdata, out_rdata;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            psba_pkg::CSR_ORIGIN_X: cfg_in.origin[0] = csr_wdata;
            psba_pkg::CSR_ORIGIN_Y: cfg_in.origin[1] = csr_wdata;
            psba_pkg::CSR_ORIGIN_Z: cfg_in.origin[2] = csr_wdata;
            psba_pkg::CSR_EXTENT_X: cfg_in.extent[0] = csr_wdata[psba_pkg::EXT_W-1:0];
            psba_pkg::CSR_EXTENT_Y: cfg_in.extent[1] = csr_wdata[psba_pkg::EXT_W-1:0];
            psba_pkg::CSR_EXTENT_Z: cfg_in.extent[2] = csr_wdata[psba_pkg::EXT_W-1:0];
            psba_pkg::CSR_MODE:     cfg_in.mode      = csr_wdata[psba_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.extent <= {psba_pkg::NUM_AXES{psba_pkg::EXTENT_RESET}};
         cfg_ff.mode   <= psba_pkg::MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psba_front #(.BINS_PER_AXIS(BINS_PER_AXIS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .back_status (back_status),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .mid_push    (mid_push),
      .mid_full    (mid_full),
      .mid_data    (mid_front)
   );

   assign mid_wdata = mid_front;
   assign mid_back  = mid_rdata;

   psba_fifo #(.W(MID_W), .DEPTH(2)) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .full  (mid_full),
      .wdata (mid_wdata),
      .pop   (mid_pop),
      .empty (mid_empty),
      .rdata (mid_rdata)
   );

   psba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .avg_en    (cfg_ff.mode[psba_pkg::MODE_AVG]),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_data  (mid_back),
      .out_push  (out_push),
      .out_full  (out_full),
      .out_data  (out_data),
      .status    (back_status)
   );

   assign out_wdata = out_data;
   assign rsp_data  = out_rdata;

   psba_fifo #(.W(RSP_W), .DEPTH(2)) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (out_wdata),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (out_rdata)
   );

endmodule
`default_nettype wire
